@@ rtl/ada_pkg.sv @@
// shared types, constants and arithmetic helpers of the attractor density unit
package ada_pkg;

    localparam int IMG_WIDTH  = 256;
    localparam int IMG_HEIGHT = 256;
    localparam int DEPTH      = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int ROW_W      = (IMG_HEIGHT > 2) ? $clog2(IMG_HEIGHT) : 1;
    localparam int COL_W      = (IMG_WIDTH > 2) ? $clog2(IMG_WIDTH) : 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [63:0] INV_TWO_PI = 64'sd683565276;
    localparam logic [16:0] K_A = 17'd102944;
    localparam logic [15:0] K_B = 16'd42047;
    localparam logic [12:0] K_C = 13'd4640;
    localparam logic [7:0]  SAT_COUNT = 8'd200;

    localparam logic [15:0] RST_COEF_A = 16'd13443;
    localparam logic [15:0] RST_COEF_B = 16'd15581;
    localparam logic [15:0] RST_COEF_C = 16'd2589;
    localparam logic [15:0] RST_COEF_D = 16'd12493;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_ITER    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } ada_op_t;

    typedef enum logic [2:0] {
        REG_COEF_A  = 3'd0,
        REG_COEF_B  = 3'd1,
        REG_COEF_C  = 3'd2,
        REG_COEF_D  = 3'd3,
        REG_START_X = 3'd4,
        REG_START_Y = 3'd5
    } ada_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_MAP,
        ST_RD,
        ST_USE,
        ST_FIN
    } ada_state_t;

    typedef struct packed {
        logic       capture;
        logic       load_start;
        logic       clr_init;
        logic       clr_step;
        logic       issue;
        logic [1:0] eval_sel;
        logic       map_pt;
        logic       mem_upd;
        logic       upd_iter;
        logic       out_load;
        logic       out_zero;
    } ada_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic eval_done;
        logic out_busy;
    } ada_status_t;

    // floor((v/4 + 0.5) * size) with clamp to size-1
    function automatic logic [11:0] to_pixel(input logic signed [15:0] v,
                                             input logic [12:0] size);
        logic signed [16:0] s;
        logic [15:0]        sc;
        logic [31:0]        prod;
        logic [31:0]        idx;
        s = 17'(v) + 17'sd16384;
        if (s < 0) begin
            sc = 16'd0;
        end else if (s > 17'sd32768) begin
            sc = 16'd32768;
        end else begin
            sc = s[15:0];
        end
        prod = 32'(sc) * 32'(size);
        idx  = prod >> 15;
        if (idx > 32'(size) - 32'd1) begin
            idx = 32'(size) - 32'd1;
        end
        return idx[11:0];
    endfunction

endpackage

@@ rtl/ada_ram.sv @@
// generic single write port ram with registered read
module ada_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ada_ctrl.sv @@
// controller state machine sequencing clear, evaluation, update and read
module ada_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    output logic                in_ready,
    output ada_pkg::ada_cmd_t   cmd,
    input  ada_pkg::ada_status_t status
);

    ada_pkg::ada_state_t state_reg, state_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                zero_pend_reg, zero_pend_next;
    logic                iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ada_pkg::ST_CLEAR;
            cnt_reg       <= 2'd0;
            zero_pend_reg <= 1'b0;
            iter_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            zero_pend_reg <= zero_pend_next;
            iter_reg      <= iter_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        zero_pend_next = zero_pend_reg;
        iter_next      = iter_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ada_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = zero_pend_reg ? ada_pkg::ST_FIN : ada_pkg::ST_IDLE;
                end
            end
            ada_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid) begin
                    cnt_next  = 2'd0;
                    iter_next = 1'b0;
                    case (in_cmd)
                        ada_pkg::CMD_RESTART: begin
                            cmd.load_start = 1'b1;
                            cmd.clr_init   = 1'b1;
                            zero_pend_next = 1'b1;
                            state_next     = ada_pkg::ST_CLEAR;
                        end
                        ada_pkg::CMD_ITER: begin
                            iter_next  = 1'b1;
                            state_next = ada_pkg::ST_ISSUE;
                        end
                        ada_pkg::CMD_READ: begin
                            zero_pend_next = 1'b0;
                            state_next     = ada_pkg::ST_RD;
                        end
                        default: begin
                            zero_pend_next = 1'b1;
                            state_next     = ada_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            ada_pkg::ST_ISSUE: begin
                cmd.issue    = 1'b1;
                cmd.eval_sel = cnt_reg;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = ada_pkg::ST_WAIT;
                end
            end
            ada_pkg::ST_WAIT: begin
                if (status.eval_done) begin
                    state_next = ada_pkg::ST_MAP;
                end
            end
            ada_pkg::ST_MAP: begin
                cmd.map_pt     = 1'b1;
                zero_pend_next = 1'b0;
                state_next     = ada_pkg::ST_RD;
            end
            ada_pkg::ST_RD: begin
                state_next = ada_pkg::ST_USE;
            end
            ada_pkg::ST_USE: begin
                cmd.mem_upd  = 1'b1;
                cmd.upd_iter = iter_reg;
                state_next   = ada_pkg::ST_FIN;
            end
            ada_pkg::ST_FIN: begin
                if (!status.out_busy) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_zero   = zero_pend_reg;
                    zero_pend_next = 1'b0;
                    state_next     = ada_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ada_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ada_datapath.sv @@
// datapath: config registers, sine pipeline, pixel mapping, density store, result register
module ada_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ada_pkg::ada_cmd_t               cmd,
    output ada_pkg::ada_status_t            status,
    input  logic [7:0]                      read_row,
    input  logic [7:0]                      read_col,
    input  logic                            cfg_we,
    input  logic [ada_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ada_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [7:0]                      hit_row,
    output logic [7:0]                      hit_col,
    output logic [7:0]                      density
);

    logic signed [15:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [14:0] start_x_reg, start_y_reg;
    logic signed [15:0] point_x_reg, point_y_reg;
    logic signed [15:0] nx_reg, ny_reg;

    // sine pipeline
    logic               v_p_reg, v_ph_reg, v_z2_reg, v_t1_reg, v_t2_reg, v_s_reg;
    logic [1:0]         g_p_reg, g_ph_reg, g_z2_reg, g_t1_reg, g_t2_reg, g_s_reg;
    logic signed [31:0] p_reg;
    logic [15:0]        ph_reg;
    logic [14:0]        az_z2_reg, az_t1_reg, az_t2_reg;
    logic               neg_z2_reg, neg_t1_reg, neg_t2_reg;
    logic [14:0]        z2_reg, z2_t1_reg;
    logic [15:0]        t1_reg;
    logic [16:0]        t2_reg;
    logic signed [14:0] s_reg;

    logic signed [15:0] op_coef, op_coord;
    logic signed [63:0] t_next;
    logic [15:0]        ph_next;
    logic [13:0]        r_val;
    logic [14:0]        az_next;
    logic [29:0]        azsq;
    logic [27:0]        z2c;
    logic [30:0]        z2t1;
    logic [32:0]        m_full;
    logic [15:0]        m_val;
    logic [13:0]        m_clamp;

    // store access
    logic [ada_pkg::ADDR_W-1:0] addr_reg, clr_cnt_reg;
    logic                       in_range_reg;
    logic [7:0]                 hr_reg, hc_reg, dens_reg;
    logic [7:0]                 rdata, dens_new;
    logic                       mem_we;
    logic [ada_pkg::ADDR_W-1:0] mem_waddr;
    logic [7:0]                 mem_wdata;
    logic [ada_pkg::ROW_W-1:0]  row_val;
    logic [ada_pkg::COL_W-1:0]  col_val;
    logic                       rd_in_range;

    logic       out_valid_reg;
    logic [7:0] out_row_reg, out_col_reg, out_dens_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg  <= ada_pkg::RST_COEF_A;
            coef_b_reg  <= ada_pkg::RST_COEF_B;
            coef_c_reg  <= ada_pkg::RST_COEF_C;
            coef_d_reg  <= ada_pkg::RST_COEF_D;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                ada_pkg::REG_COEF_A:  coef_a_reg  <= cfg_data;
                ada_pkg::REG_COEF_B:  coef_b_reg  <= cfg_data;
                ada_pkg::REG_COEF_C:  coef_c_reg  <= cfg_data;
                ada_pkg::REG_COEF_D:  coef_d_reg  <= cfg_data;
                ada_pkg::REG_START_X: start_x_reg <= cfg_data[14:0];
                ada_pkg::REG_START_Y: start_y_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // operand select: sin(a*y), cos(b*x), sin(c*x), cos(d*y)
    always_comb begin
        case (cmd.eval_sel)
            2'd0: begin op_coef = coef_a_reg; op_coord = point_y_reg; end
            2'd1: begin op_coef = coef_b_reg; op_coord = point_x_reg; end
            2'd2: begin op_coef = coef_c_reg; op_coord = point_x_reg; end
            default: begin op_coef = coef_d_reg; op_coord = point_y_reg; end
        endcase
    end

    always_comb begin
        t_next  = 64'(p_reg) * ada_pkg::INV_TWO_PI;
        ph_next = t_next[57:42] + (g_p_reg[0] ? 16'd16384 : 16'd0);
        r_val   = ph_reg[13:0];
        az_next = ph_reg[14] ? 15'(15'd16384 - 15'(r_val)) : 15'(r_val);
        azsq    = 30'(az_next) * 30'(az_next);
        z2c     = 28'(z2_reg) * 28'(ada_pkg::K_C);
        z2t1    = 31'(z2_t1_reg) * 31'(t1_reg);
        m_full  = 33'(az_t2_reg) * 33'(t2_reg) + 33'd65536;
        m_val   = m_full[32:17];
        m_clamp = (m_val > 16'd8192) ? 14'd8192 : m_val[13:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_p_reg  <= 1'b0;
            v_ph_reg <= 1'b0;
            v_z2_reg <= 1'b0;
            v_t1_reg <= 1'b0;
            v_t2_reg <= 1'b0;
            v_s_reg  <= 1'b0;
        end else begin
            v_p_reg  <= cmd.issue;
            v_ph_reg <= v_p_reg;
            v_z2_reg <= v_ph_reg;
            v_t1_reg <= v_z2_reg;
            v_t2_reg <= v_t1_reg;
            v_s_reg  <= v_t2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg      <= 32'(op_coef) * 32'(op_coord);
        g_p_reg    <= cmd.eval_sel;
        ph_reg     <= ph_next;
        g_ph_reg   <= g_p_reg;
        z2_reg     <= 15'(azsq >> 14);
        az_z2_reg  <= az_next;
        neg_z2_reg <= ph_reg[15];
        g_z2_reg   <= g_ph_reg;
        t1_reg     <= ada_pkg::K_B - 16'(z2c >> 14);
        z2_t1_reg  <= z2_reg;
        az_t1_reg  <= az_z2_reg;
        neg_t1_reg <= neg_z2_reg;
        g_t1_reg   <= g_z2_reg;
        t2_reg     <= ada_pkg::K_A - 17'(z2t1 >> 14);
        az_t2_reg  <= az_t1_reg;
        neg_t2_reg <= neg_t1_reg;
        g_t2_reg   <= g_t1_reg;
        s_reg      <= neg_t2_reg ? -15'(m_clamp) : 15'(m_clamp);
        g_s_reg    <= g_t2_reg;
    end

    assign status.eval_done = v_s_reg && (g_s_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (v_s_reg) begin
            case (g_s_reg)
                2'd0: nx_reg <= 16'(s_reg);
                2'd1: nx_reg <= nx_reg - 16'(s_reg);
                2'd2: ny_reg <= 16'(s_reg);
                default: ny_reg <= ny_reg - 16'(s_reg);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end else if (cmd.load_start) begin
            point_x_reg <= 16'(start_x_reg);
            point_y_reg <= 16'(start_y_reg);
        end else if (cmd.map_pt) begin
            point_x_reg <= nx_reg;
            point_y_reg <= ny_reg;
        end
    end

    always_comb begin
        row_val = ada_pkg::ROW_W'(ada_pkg::to_pixel(ny_reg, 13'(ada_pkg::IMG_HEIGHT)));
        col_val = ada_pkg::COL_W'(ada_pkg::to_pixel(nx_reg, 13'(ada_pkg::IMG_WIDTH)));
        rd_in_range = (13'(read_row) < 13'(ada_pkg::IMG_HEIGHT))
                   && (13'(read_col) < 13'(ada_pkg::IMG_WIDTH));
        dens_new = (rdata < ada_pkg::SAT_COUNT) ? rdata + 8'd1 : rdata;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            hr_reg       <= read_row;
            hc_reg       <= read_col;
            in_range_reg <= rd_in_range;
            addr_reg     <= ada_pkg::ADDR_W'(ada_pkg::ROW_W'(read_row))
                          * ada_pkg::ADDR_W'(ada_pkg::IMG_WIDTH)
                          + ada_pkg::ADDR_W'(ada_pkg::COL_W'(read_col));
        end else if (cmd.map_pt) begin
            hr_reg       <= 8'(row_val);
            hc_reg       <= 8'(col_val);
            in_range_reg <= 1'b1;
            addr_reg     <= ada_pkg::ADDR_W'(row_val) * ada_pkg::ADDR_W'(ada_pkg::IMG_WIDTH)
                          + ada_pkg::ADDR_W'(col_val);
        end
        if (cmd.mem_upd) begin
            dens_reg <= cmd.upd_iter ? dens_new : (in_range_reg ? rdata : 8'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_init) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= status.clr_last ? '0 : clr_cnt_reg + ada_pkg::ADDR_W'(1);
        end
    end

    assign status.clr_last = (clr_cnt_reg == ada_pkg::ADDR_W'(ada_pkg::DEPTH - 1));

    assign mem_we    = cmd.clr_step || (cmd.mem_upd && cmd.upd_iter);
    assign mem_waddr = cmd.clr_step ? clr_cnt_reg : addr_reg;
    assign mem_wdata = cmd.clr_step ? 8'd0 : dens_new;

    ada_ram #(
        .WIDTH (8),
        .DEPTH (ada_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_row_reg  <= cmd.out_zero ? 8'd0 : hr_reg;
            out_col_reg  <= cmd.out_zero ? 8'd0 : hc_reg;
            out_dens_reg <= cmd.out_zero ? 8'd0 : dens_reg;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign hit_row   = out_row_reg;
    assign hit_col   = out_col_reg;
    assign density   = out_dens_reg;

endmodule

@@ rtl/attractor_density_accumulator_unit.sv @@
// top level of the de jong attractor density accumulator
// An iterate command issues four sine/cosine evaluations one per cycle into a
// shared six-stage pipeline, then the pixel is mapped and its count is read,
// incremented up to saturation and written back through the store's single
// port pair. A read command returns the count of the given pixel, zero outside
// the image. A restart command, and reset, clear the 65536-entry density store
// one entry a cycle, and no command is accepted while the store is cleared.
// Configuration writes are taken in every cycle. The result register lets a
// new command enter while the previous result waits to be taken.
module attractor_density_accumulator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // read_row, read_col
    input  logic [1:0]                     s_tuser,   // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // hit_row, hit_col, density
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ada_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ada_pkg::CFG_DATA_W-1:0] cfg_data
);

    ada_pkg::ada_cmd_t    cmd;
    ada_pkg::ada_status_t status;
    logic [7:0]           hit_row, hit_col, density;

    assign cfg_ready = 1'b1;

    ada_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ada_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .read_row  (s_tdata[7:0]),
        .read_col  (s_tdata[15:8]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .hit_row   (hit_row),
        .hit_col   (hit_col),
        .density   (density)
    );

    assign m_tdata = {density, hit_col, hit_row};

endmodule

@@ rtl/ada_checker.sv @@
// port level checks of the attractor density unit and their bind
module ada_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // count never passes saturation
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:16] <= ada_pkg::SAT_COUNT)
        else $error("density above saturation");

    // restart transfer starts the clearing pass
    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ada_pkg::CMD_RESTART |=> !s_tready)
        else $error("input ready during clear");

endmodule

bind attractor_density_accumulator_unit ada_checker u_ada_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
